[sv/cmb_pkg.sv]
package cmb_pkg;

    // Field and register widths
    localparam int C_BASE_W     = 2;
    localparam int C_MIN_W      = 32;
    localparam int C_BUCKET_W   = 10;
    localparam int C_KMER_W     = 6;
    localparam int C_PREFIX_W   = 4;
    localparam int C_PFX_EFF_W  = 5;
    localparam int C_CFG_IDX_W  = 2;
    localparam int C_CFG_DATA_W = 6;

    // Default sizes
    localparam int C_MAX_PREFIX  = 8;
    localparam int C_NUM_BUCKETS = 1020;

    // Register indexes
    localparam logic [C_CFG_IDX_W-1:0] CFG_KMER_LEN   = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_PREFIX_LEN = 2'd1;

    // Input beat
    typedef struct packed {
        logic [C_BASE_W-1:0] base;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic [C_MIN_W-1:0]    minimizer;
        logic [C_BUCKET_W-1:0] bucket;
        logic                  too_short;
    } t_out_beat;

    // Settings handed from the register block to the core
    typedef struct packed {
        logic [C_KMER_W-1:0]    kmer_len;
        logic [C_PFX_EFF_W-1:0] prefix;    // clamped to 1..MAX_PREFIX
        logic                   clear;     // a register was written
    } t_cfg;

endpackage

[sv/cmb_stream_if.sv]
interface cmb_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/canonical_minimizer_bucketer.sv]
// Canonical minimizer bucketer. Takes one 2-bit DNA base per beat and, on the
// last base of every k-mer (kmer_len bases), returns one result beat: the
// smallest 2*prefix_len-base window of the k-mer over both strands, the bucket
// formed by its first prefix_len bases (saturated at 1019), and too_short when
// the k-mer is shorter than one window (then minimizer and bucket are zero).
// A base is taken every cycle while result beats are taken; a result beat left
// waiting stops the core; the held input base then waits until it goes.
// One input register and one result register lie around the single-pass window
// shift and minimum compare. Writing either register drops the k-mer in
// progress; write only while no base is in flight.
module canonical_minimizer_bucketer
    import cmb_pkg::*;
#(
    parameter int MAX_PREFIX = C_MAX_PREFIX
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [C_CFG_DATA_W-1:0] i_cfg_data,
    cmb_stream_if.sink              i_in,
    cmb_stream_if.source            o_out
);

    t_cfg                cfg;
    logic                r_in_vld;
    logic [C_BASE_W-1:0] r_base;
    logic                r_out_vld;
    t_out_beat           r_out;
    logic                consume;
    logic                emit;
    t_out_beat           res;

    cmb_cfg_regs #(
        .MAX_PREFIX (MAX_PREFIX)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    cmb_kmer_core #(
        .MAX_PREFIX (MAX_PREFIX)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (consume),
        .i_base  (r_base),
        .o_emit  (emit),
        .o_res   (res)
    );

    // Move the held base into the core when the result slot can take it
    assign consume     = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_in_vld || consume;

    // Hold the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_vld <= 1'b1;
        end else if (consume) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_base <= i_in.data.base;
        end
    end

    // Hold the result beat until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (consume && emit) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && emit) begin
            r_out <= res;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

`ifndef SYNTH
    // A short k-mer carries no minimizer or bucket
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.too_short |->
            o_out.data.minimizer == '0 && o_out.data.bucket == '0)
        else $error("too_short result with nonzero fields");

    // The bucket never passes the saturation value
    a_bucket_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.bucket <= C_BUCKET_W'(C_NUM_BUCKETS - 1))
        else $error("bucket above saturation value");

    // An empty input register always takes a beat
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> i_in.ready)
        else $error("input stalled with empty input register");

    // A stalled result blocks the core from stepping
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_out.ready |-> !consume)
        else $error("core stepped while result beat was stalled");
`endif

endmodule

[sv/cmb_cfg_regs.sv]
module cmb_cfg_regs
    import cmb_pkg::*;
#(
    parameter int MAX_PREFIX = C_MAX_PREFIX
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [C_CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                    o_cfg
);

    logic [C_KMER_W-1:0]    r_kmer_len;
    logic [C_PREFIX_W-1:0]  r_prefix_len;
    logic [C_PFX_EFF_W-1:0] prefix_ext;
    logic                   hit;

    // Decode the register index
    always_comb begin
        hit = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KMER_LEN:   hit = 1'b1;
                CFG_PREFIX_LEN: hit = 1'b1;
                default:        hit = 1'b0;
            endcase
        end
    end

    // Hold the register values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len   <= C_KMER_W'(31);
            r_prefix_len <= C_PREFIX_W'(4);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_KMER_LEN) begin
                r_kmer_len <= i_cfg_data[C_KMER_W-1:0];
            end
            if (i_cfg_idx == CFG_PREFIX_LEN) begin
                r_prefix_len <= i_cfg_data[C_PREFIX_W-1:0];
            end
        end
    end

    // Clamp the prefix length to 1..MAX_PREFIX
    assign prefix_ext = {1'b0, r_prefix_len};

    always_comb begin
        o_cfg.kmer_len = r_kmer_len;
        o_cfg.clear    = hit;
        priority if (prefix_ext == '0) begin
            o_cfg.prefix = C_PFX_EFF_W'(1);
        end else if (prefix_ext > C_PFX_EFF_W'(MAX_PREFIX)) begin
            o_cfg.prefix = C_PFX_EFF_W'(MAX_PREFIX);
        end else begin
            o_cfg.prefix = prefix_ext;
        end
    end

endmodule

[sv/cmb_kmer_core.sv]
module cmb_kmer_core
    import cmb_pkg::*;
#(
    parameter int MAX_PREFIX = C_MAX_PREFIX
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_step,
    input  logic [C_BASE_W-1:0] i_base,
    output logic                o_emit,
    output t_out_beat           o_res
);

    localparam int SLOTS = 2 * MAX_PREFIX;
    localparam int WIN_W = 2 * SLOTS;
    localparam int WLN_W = C_PFX_EFF_W + 1;
    localparam int EXT_W = WIN_W + C_BUCKET_W;

    logic [WIN_W-1:0]    r_fwd, r_rev, r_best;
    logic [C_KMER_W-1:0] r_count;
    logic [WIN_W-1:0]    n_fwd, n_rev, n_best;
    logic [C_KMER_W-1:0] n_count;

    logic [WIN_W-1:0]     fwd_shift, rev_shift, min_a, min_b, pre;
    logic [WLN_W-1:0]     win_len;
    logic [EXT_W-1:0]     pre_ext;
    logic [WIN_W+C_MIN_W-1:0] best_ext;
    logic                 too_short;

    assign win_len   = {i_cfg.prefix, 1'b0};
    assign n_count   = r_count + C_KMER_W'(1);
    assign too_short = i_cfg.kmer_len < win_len;
    assign o_emit    = n_count >= i_cfg.kmer_len;

    // Shift the new base into both strands, dropping slots past the window
    assign fwd_shift = {r_fwd[WIN_W-3:0], i_base};
    assign rev_shift = {2'b00, r_rev[WIN_W-1:2]};

    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            n_fwd[2*j +: 2] = (WLN_W'(j) < win_len) ? fwd_shift[2*j +: 2] : 2'b00;
            n_rev[2*j +: 2] = (WLN_W'(j) == win_len - WLN_W'(1)) ? ~i_base
                                                                  : rev_shift[2*j +: 2];
        end
    end

    // Running minimum over both strands once the window is full
    assign min_a = (n_fwd < r_best) ? n_fwd : r_best;
    assign min_b = (n_rev < min_a) ? n_rev : min_a;
    assign n_best = (n_count >= win_len) ? min_b : r_best;

    // Bucket: minimizer prefix, saturated
    assign pre      = n_best >> win_len;
    assign pre_ext  = {{C_BUCKET_W{1'b0}}, pre};
    assign best_ext = {{C_MIN_W{1'b0}}, n_best};

    always_comb begin
        if (too_short) begin
            o_res.minimizer = '0;
            o_res.bucket    = '0;
            o_res.too_short = 1'b1;
        end else begin
            o_res.minimizer = best_ext[C_MIN_W-1:0];
            o_res.too_short = 1'b0;
            if (pre_ext > EXT_W'(C_NUM_BUCKETS - 1)) begin
                o_res.bucket = C_BUCKET_W'(C_NUM_BUCKETS - 1);
            end else begin
                o_res.bucket = pre_ext[C_BUCKET_W-1:0];
            end
        end
    end

    // Advance the k-mer state; drop it at the end of a k-mer or on a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.clear || (i_step && o_emit)) begin
            r_fwd   <= '0;
            r_rev   <= '0;
            r_best  <= '1;
            r_count <= '0;
        end else if (i_step) begin
            r_fwd   <= n_fwd;
            r_rev   <= n_rev;
            r_best  <= n_best;
            r_count <= n_count;
        end
    end

endmodule
